// ----- design/motor_command_safe_stop_handshake_top_macros.svh -----
// ----------------------------------------------------------------------------
// Safe-stop handshake assertion macros
// Shared concurrent assertion forms for the handshake block.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_SAFE_STOP_HANDSHAKE_TOP_MACROS_SVH
`define MOTOR_COMMAND_SAFE_STOP_HANDSHAKE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MCSSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcssh assertion failed");

// Next-cycle implication, disabled during reset
`define MCSSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcssh assertion failed");

`endif

// ----- design/mcssh_pkg.sv -----
// ----------------------------------------------------------------------------
// Safe-stop handshake package
// Types, codes and constants shared by the handshake block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcssh_pkg;

    localparam int GEN_W  = 32;
    localparam int WAIT_W = 16;
    localparam int IDX_W  = 2;

    localparam logic [GEN_W-1:0] GEN_TOP = {GEN_W{1'b1}};

    // Config reset values
    localparam logic [WAIT_W-1:0] MAX_WAIT_RST = WAIT_W'(10);
    localparam logic [WAIT_W-1:0] CMD_TO_RST   = WAIT_W'(100);

    // Config register indexes
    localparam logic [IDX_W-1:0] REG_MAX_WAIT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_CMD_TO   = IDX_W'(1);

    // Consumer status codes
    localparam logic [1:0] STAT_SAFE   = 2'd0;
    localparam logic [1:0] STAT_ACTIVE = 2'd1;
    localparam logic [1:0] STAT_TRANS  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ACTIVATE   = 2'd1,
        OP_DEACTIVATE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        MODE_INACTIVE = 3'd0,
        MODE_SEEDING  = 3'd1,
        MODE_ACTIVE   = 3'd2,
        MODE_STOPPING = 3'd3,
        MODE_SAFE     = 3'd4,
        MODE_FAULT    = 3'd5
    } t_mode;

    typedef struct packed {
        logic [1:0]       operation;
        logic             observed_valid;
        logic [GEN_W-1:0] observed_session;
        logic [GEN_W-1:0] observed_ack_generation;
        logic [GEN_W-1:0] observed_safe_generation;
        logic [GEN_W-1:0] observed_safe_ack;
        logic [1:0]       observed_status;
        logic             stop_request;
        logic             new_command;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       proto_state;
        logic             error;
        logic             command_written;
        logic             seed_command;
        logic [GEN_W-1:0] command_generation;
        logic [GEN_W-1:0] session_out;
        logic             safe_request_written;
        logic [GEN_W-1:0] safe_request_generation;
        logic             safe_acknowledged;
        logic             stop_failed;
    } t_out_item;

    typedef struct packed {
        logic [WAIT_W-1:0] max_wait_ticks;
        logic [WAIT_W-1:0] command_timeout_ticks;
    } t_cfg;

endpackage

// ----- design/mcssh_cfg.sv -----
// ----------------------------------------------------------------------------
// Safe-stop handshake configuration registers
// Holds the wait limit and the command timeout, written through a valid/ready port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcssh_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mcssh_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [mcssh_pkg::WAIT_W-1:0]        i_cfg_data,
    output logic                                o_cfg_ready,
    output mcssh_pkg::t_cfg                     o_cfg
);

    mcssh_pkg::t_cfg r_cfg;

    // Always ready: each write goes straight into the register
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_wait_ticks        <= mcssh_pkg::MAX_WAIT_RST;
            r_cfg.command_timeout_ticks <= mcssh_pkg::CMD_TO_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcssh_pkg::REG_MAX_WAIT: r_cfg.max_wait_ticks        <= i_cfg_data;
                mcssh_pkg::REG_CMD_TO:   r_cfg.command_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- design/mcssh_core.sv -----
// ----------------------------------------------------------------------------
// Safe-stop handshake protocol core
// Protocol state registers and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcssh_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  mcssh_pkg::t_in_item   i_item,
    input  mcssh_pkg::t_cfg       i_cfg,
    output mcssh_pkg::t_out_item  o_result
);

    typedef struct packed {
        mcssh_pkg::t_mode                mode;
        logic [mcssh_pkg::GEN_W-1:0]     session;
        logic [mcssh_pkg::GEN_W-1:0]     gen;
        logic [mcssh_pkg::GEN_W-1:0]     req_gen;
        logic [mcssh_pkg::WAIT_W-1:0]    wait_cnt;
        logic [mcssh_pkg::WAIT_W-1:0]    age;
        logic                            ext_seen;
        logic                            safe_done;
        logic                            fault;
    } t_state;

    t_state r_st;
    t_state n_st;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode      <= mcssh_pkg::MODE_INACTIVE;
            r_st.session   <= '0;
            r_st.gen       <= '0;
            r_st.req_gen   <= '0;
            r_st.wait_cnt  <= '0;
            r_st.age       <= '0;
            r_st.ext_seen  <= 1'b0;
            r_st.safe_done <= 1'b0;
            r_st.fault     <= 1'b0;
        end else if (i_go) begin
            r_st <= n_st;
        end
    end

    // Next state and result for one item
    always_comb begin : step
        logic                         proto_ok;
        logic                         ask_ok;
        logic                         stopping;
        logic                         need_ask;
        logic                         need_cmd;
        logic                         err;
        logic                         req_wr;
        logic                         seed;
        logic [mcssh_pkg::GEN_W-1:0]  cmd_gen;
        logic [mcssh_pkg::GEN_W-1:0]  next_req;
        logic [mcssh_pkg::GEN_W-1:0]  rg;
        logic [mcssh_pkg::WAIT_W-1:0] wc;

        n_st     = r_st;
        err      = 1'b0;
        req_wr   = 1'b0;
        seed     = 1'b0;
        cmd_gen  = '0;
        need_ask = 1'b0;
        need_cmd = 1'b0;
        stopping = 1'b0;
        rg       = '0;
        wc       = '0;
        next_req = i_item.observed_safe_generation + mcssh_pkg::GEN_W'(1);

        // Observed values must match the protocol phase
        proto_ok = 1'b0;
        if (i_item.observed_valid && (i_item.observed_session == r_st.session)) begin
            case (r_st.mode)
                mcssh_pkg::MODE_SEEDING:
                    proto_ok = (r_st.gen == '0) ? (i_item.observed_status == mcssh_pkg::STAT_SAFE)
                                                : (i_item.observed_status == mcssh_pkg::STAT_ACTIVE);
                mcssh_pkg::MODE_ACTIVE:
                    proto_ok = (i_item.observed_status == mcssh_pkg::STAT_ACTIVE);
                mcssh_pkg::MODE_STOPPING:
                    proto_ok = (i_item.observed_status == mcssh_pkg::STAT_TRANS) ||
                               (i_item.observed_status == mcssh_pkg::STAT_SAFE);
                default:
                    proto_ok = 1'b0;
            endcase
        end

        // A safe-stop request needs a session, a valid observation and room for one more generation
        ask_ok = (r_st.session != '0) && i_item.observed_valid &&
                 (i_item.observed_safe_generation != mcssh_pkg::GEN_TOP);

        case (mcssh_pkg::t_op'(i_item.operation))
            mcssh_pkg::OP_TICK: begin
                if ((r_st.mode == mcssh_pkg::MODE_INACTIVE) ||
                    (r_st.mode == mcssh_pkg::MODE_SAFE)) begin
                    // idle phases ignore ticks
                end else if (!proto_ok) begin
                    n_st.mode  = mcssh_pkg::MODE_FAULT;
                    n_st.fault = 1'b1;
                    err        = 1'b1;
                end else if (i_item.stop_request && (r_st.mode != mcssh_pkg::MODE_STOPPING) &&
                             !ask_ok) begin
                    n_st.mode  = mcssh_pkg::MODE_FAULT;
                    n_st.fault = 1'b1;
                    err        = 1'b1;
                end else begin
                    // External stop enters stopping and is checked on this same tick
                    if (r_st.mode == mcssh_pkg::MODE_STOPPING) begin
                        stopping = 1'b1;
                        rg       = r_st.req_gen;
                        wc       = r_st.wait_cnt;
                    end else if (i_item.stop_request) begin
                        stopping     = 1'b1;
                        rg           = next_req;
                        wc           = '0;
                        req_wr       = 1'b1;
                        n_st.req_gen = next_req;
                        n_st.mode    = mcssh_pkg::MODE_STOPPING;
                    end

                    if (stopping) begin
                        if ((rg != '0) && (i_item.observed_safe_generation == rg) &&
                            (i_item.observed_safe_ack == rg) &&
                            (i_item.observed_status == mcssh_pkg::STAT_SAFE)) begin
                            n_st.mode      = mcssh_pkg::MODE_SAFE;
                            n_st.safe_done = 1'b1;
                            n_st.wait_cnt  = wc;
                        end else if (wc >= i_cfg.max_wait_ticks) begin
                            n_st.mode     = mcssh_pkg::MODE_FAULT;
                            n_st.fault    = 1'b1;
                            n_st.wait_cnt = wc;
                            err           = 1'b1;
                        end else begin
                            n_st.wait_cnt = wc + mcssh_pkg::WAIT_W'(1);
                        end
                    end else if ((r_st.gen != '0) &&
                                 (i_item.observed_ack_generation != r_st.gen)) begin
                        // Waiting for the last command to be acknowledged
                        if (r_st.wait_cnt >= i_cfg.max_wait_ticks)
                            need_ask = 1'b1;
                        else
                            n_st.wait_cnt = r_st.wait_cnt + mcssh_pkg::WAIT_W'(1);
                    end else begin
                        n_st.wait_cnt = '0;
                        if ((r_st.mode == mcssh_pkg::MODE_SEEDING) && (r_st.gen != '0)) begin
                            // seed acknowledged
                            n_st.mode = mcssh_pkg::MODE_ACTIVE;
                            n_st.age  = '0;
                        end else if (i_item.new_command) begin
                            n_st.age      = '0;
                            n_st.ext_seen = 1'b1;
                            need_cmd      = 1'b1;
                        end else if ((r_st.mode == mcssh_pkg::MODE_ACTIVE) && r_st.ext_seen) begin
                            if (r_st.age >= i_cfg.command_timeout_ticks) begin
                                need_ask = 1'b1;
                            end else begin
                                n_st.age = r_st.age + mcssh_pkg::WAIT_W'(1);
                                need_cmd = 1'b1;
                            end
                        end else begin
                            need_cmd = 1'b1;
                        end
                    end

                    // Stop after missing ack or stale commands
                    if (need_ask) begin
                        if (ask_ok) begin
                            req_wr        = 1'b1;
                            n_st.req_gen  = next_req;
                            n_st.mode     = mcssh_pkg::MODE_STOPPING;
                            n_st.wait_cnt = '0;
                        end else begin
                            n_st.mode  = mcssh_pkg::MODE_FAULT;
                            n_st.fault = 1'b1;
                            err        = 1'b1;
                        end
                    end

                    // Numbered command; generation may not wrap
                    if (need_cmd) begin
                        if (r_st.gen == mcssh_pkg::GEN_TOP) begin
                            n_st.mode  = mcssh_pkg::MODE_FAULT;
                            n_st.fault = 1'b1;
                            err        = 1'b1;
                        end else begin
                            n_st.gen = r_st.gen + mcssh_pkg::GEN_W'(1);
                            cmd_gen  = r_st.gen + mcssh_pkg::GEN_W'(1);
                            seed     = (r_st.mode == mcssh_pkg::MODE_SEEDING);
                        end
                    end
                end
            end
            mcssh_pkg::OP_ACTIVATE: begin
                if (!i_item.observed_valid || (i_item.observed_session == '0)) begin
                    err = 1'b1;
                end else begin
                    n_st.session   = i_item.observed_session;
                    n_st.gen       = '0;
                    n_st.req_gen   = '0;
                    n_st.wait_cnt  = '0;
                    n_st.age       = '0;
                    n_st.ext_seen  = 1'b0;
                    n_st.safe_done = 1'b0;
                    n_st.fault     = 1'b0;
                    n_st.mode      = mcssh_pkg::MODE_SEEDING;
                end
            end
            mcssh_pkg::OP_DEACTIVATE: begin
                if (r_st.safe_done)
                    n_st.mode = mcssh_pkg::MODE_INACTIVE;
                else
                    err = 1'b1;
            end
            default: begin
                err = 1'b1;
            end
        endcase

        // Result fields
        o_result.proto_state             = n_st.mode;
        o_result.error                   = err;
        o_result.command_written         = (cmd_gen != '0);
        o_result.seed_command            = (cmd_gen != '0) && seed;
        o_result.command_generation      = cmd_gen;
        o_result.session_out             = ((cmd_gen != '0) || req_wr) ? n_st.session : '0;
        o_result.safe_request_written    = req_wr;
        o_result.safe_request_generation = req_wr ? n_st.req_gen : '0;
        o_result.safe_acknowledged       = n_st.safe_done;
        o_result.stop_failed             = n_st.fault;
    end

endmodule

// ----- design/motor_command_safe_stop_handshake_top.sv -----
// Stages: an item goes from the input register through the core into the result register.
// Throughput: one item per cycle while the result is not stalled; the protocol state updates
// in one pass per item.
// A stalled result holds in the result register while one more item waits in the input register.
// Reset (synchronous, active low) clears the protocol state and both stages; the wait limit
// returns to 10 and the command timeout to 100.
// ----------------------------------------------------------------------------
// Motor command safe-stop handshake, top level
// Input register, protocol core and result register with valid/stall channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "motor_command_safe_stop_handshake_top_macros.svh"

module motor_command_safe_stop_handshake_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mcssh_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mcssh_pkg::t_out_item          o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mcssh_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [mcssh_pkg::WAIT_W-1:0]  i_cfg_data
);

    logic                 r_in_valid;
    mcssh_pkg::t_in_item  r_in;
    logic                 r_out_valid;
    mcssh_pkg::t_out_item r_out;
    logic                 core_go;
    logic                 in_take;
    mcssh_pkg::t_cfg      cfg;
    mcssh_pkg::t_out_item n_out;

    // Flow control: core fires when the result register is free or draining
    assign core_go    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !core_go;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    mcssh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    mcssh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (core_go),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (core_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_go) begin
            r_out <= n_out;
        end
    end

    // Checks on the result and the pipeline
    `MCSSH_ASSERT_IMP(a_seed_has_cmd, i_clk, i_rst_n,
        r_out_valid && r_out.seed_command, r_out.command_written)
    `MCSSH_ASSERT_IMP(a_cmd_gen_nonzero, i_clk, i_rst_n,
        r_out_valid && r_out.command_written, r_out.command_generation != '0)
    `MCSSH_ASSERT_IMP(a_req_state, i_clk, i_rst_n,
        r_out_valid && r_out.safe_request_written,
        (r_out.proto_state == mcssh_pkg::MODE_STOPPING) ||
        (r_out.proto_state == mcssh_pkg::MODE_FAULT))
    `MCSSH_ASSERT_NXT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !core_go, r_in_valid)
    `MCSSH_ASSERT_NXT(a_core_fills_out, i_clk, i_rst_n, core_go, r_out_valid)

endmodule

// ----- tb/motor_command_safe_stop_handshake_checker.sv -----
// ----------------------------------------------------------------------------
// Safe-stop handshake checker
// Watches the item, result and register channels. Keeps its own copy of the
// protocol state, predicts one result per accepted item and compares every
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_command_safe_stop_handshake_checker
    import mcssh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in_item            i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out_item           i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [WAIT_W-1:0]   i_cfg_data,
    output int                  o_fail_count,
    output int                  o_owed,
    output t_mode               o_mode,
    output logic [GEN_W-1:0]    o_gen_count,
    output logic [GEN_W-1:0]    o_safe_gen,
    output logic [GEN_W-1:0]    o_session
);

    // Register copies
    logic [WAIT_W-1:0] max_wait;
    logic [WAIT_W-1:0] cmd_timeout;

    // Protocol state as the block should hold it
    t_mode             mode;
    logic [GEN_W-1:0]  session;
    logic [GEN_W-1:0]  gen;
    logic [GEN_W-1:0]  req_gen;
    logic [WAIT_W-1:0] wait_cnt;
    logic [WAIT_W-1:0] cmd_age;
    logic              ext_seen;
    logic              safe_done;
    logic              fault_flag;
    logic              req_written;

    t_out_item         predicted_replies[$];
    int                fails = 0;

    assign o_fail_count = fails;
    assign o_mode       = mode;
    assign o_gen_count  = gen;
    assign o_safe_gen   = req_gen;
    assign o_session    = session;

    function automatic void enter_fault();
        mode       = MODE_FAULT;
        fault_flag = 1'b1;
    endfunction

    // Publish a safe-stop request one past the consumer's safe generation
    function automatic bit request_stop(input logic [GEN_W-1:0] sgen);
        if (session == '0 || sgen == GEN_TOP) begin
            enter_fault();
            return 1'b0;
        end
        req_gen     = sgen + 1'b1;
        req_written = 1'b1;
        mode        = MODE_STOPPING;
        wait_cnt    = '0;
        return 1'b1;
    endfunction

    // One control tick; returns the error bit
    function automatic bit control_tick(input t_in_item it, output logic [GEN_W-1:0] cmd_gen,
                                        output bit seed);
        bit               ok;
        logic [GEN_W-1:0] sgen;
        sgen    = it.observed_safe_generation;
        cmd_gen = '0;
        seed    = 1'b0;
        if (mode == MODE_INACTIVE || mode == MODE_SAFE)
            return 1'b0;

        // Observed values must match the protocol state
        ok = 1'b0;
        if (it.observed_valid && it.observed_session == session) begin
            case (mode)
                MODE_SEEDING:  ok = (gen == '0) ? (it.observed_status == STAT_SAFE)
                                                : (it.observed_status == STAT_ACTIVE);
                MODE_ACTIVE:   ok = (it.observed_status == STAT_ACTIVE);
                MODE_STOPPING: ok = (it.observed_status inside {STAT_TRANS, STAT_SAFE});
                default:       ok = 1'b0;
            endcase
        end
        if (!ok) begin
            enter_fault();
            return 1'b1;
        end

        if (it.stop_request && mode != MODE_STOPPING && !request_stop(sgen))
            return 1'b1;

        // Waiting for the exact safe acknowledgement
        if (mode == MODE_STOPPING) begin
            if (req_gen != '0 && sgen == req_gen && it.observed_safe_ack == req_gen &&
                it.observed_status == STAT_SAFE) begin
                mode      = MODE_SAFE;
                safe_done = 1'b1;
                return 1'b0;
            end
            if (wait_cnt >= max_wait) begin
                enter_fault();
                return 1'b1;
            end
            wait_cnt = wait_cnt + 1'b1;
            return 1'b0;
        end

        // Last command not yet acknowledged
        if (gen != '0 && it.observed_ack_generation != gen) begin
            if (wait_cnt >= max_wait)
                return !request_stop(sgen);
            wait_cnt = wait_cnt + 1'b1;
            return 1'b0;
        end
        wait_cnt = '0;

        // Seed acknowledged: go active without a command this tick
        if (mode == MODE_SEEDING && gen != '0) begin
            mode    = MODE_ACTIVE;
            cmd_age = '0;
            return 1'b0;
        end

        // Staleness of external commands
        if (it.new_command) begin
            cmd_age  = '0;
            ext_seen = 1'b1;
        end else if (mode == MODE_ACTIVE && ext_seen) begin
            if (cmd_age >= cmd_timeout)
                return !request_stop(sgen);
            cmd_age = cmd_age + 1'b1;
        end

        if (gen == GEN_TOP) begin
            enter_fault();
            return 1'b1;
        end
        gen     = gen + 1'b1;
        cmd_gen = gen;
        seed    = (mode == MODE_SEEDING);
        return 1'b0;
    endfunction

    // Expected result of one item, state updated in place
    function automatic t_out_item step_protocol(input t_in_item it);
        t_out_item        r;
        logic [GEN_W-1:0] cmd_gen;
        bit               seed;
        bit               err;
        cmd_gen     = '0;
        seed        = 1'b0;
        err         = 1'b0;
        req_written = 1'b0;
        case (it.operation)
            OP_TICK: err = control_tick(it, cmd_gen, seed);
            OP_ACTIVATE: begin
                if (!it.observed_valid || it.observed_session == '0) begin
                    err = 1'b1;
                end else begin
                    session    = it.observed_session;
                    gen        = '0;
                    req_gen    = '0;
                    wait_cnt   = '0;
                    cmd_age    = '0;
                    ext_seen   = 1'b0;
                    safe_done  = 1'b0;
                    fault_flag = 1'b0;
                    mode       = MODE_SEEDING;
                end
            end
            OP_DEACTIVATE: begin
                if (safe_done)
                    mode = MODE_INACTIVE;
                else
                    err = 1'b1;
            end
            default: err = 1'b1;
        endcase

        r                         = '0;
        r.proto_state             = mode;
        r.error                   = err;
        r.command_written         = (cmd_gen != '0);
        r.seed_command            = (cmd_gen != '0) && seed;
        r.command_generation      = cmd_gen;
        r.session_out             = (cmd_gen != '0 || req_written) ? session : '0;
        r.safe_request_written    = req_written;
        r.safe_request_generation = req_written ? req_gen : '0;
        r.safe_acknowledged       = safe_done;
        r.stop_failed             = fault_flag;
        return r;
    endfunction

    function automatic string describe(input t_out_item r);
        return $sformatf({"state=%0d err=%0b cmd=%0b seed=%0b gen=%h sess=%h ",
                          "req=%0b rgen=%h ack=%0b fail=%0b"},
                         r.proto_state, r.error, r.command_written, r.seed_command,
                         r.command_generation, r.session_out, r.safe_request_written,
                         r.safe_request_generation, r.safe_acknowledged, r.stop_failed);
    endfunction

    // Channel monitor: results are checked before the new item is predicted
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            max_wait    = MAX_WAIT_RST;
            cmd_timeout = CMD_TO_RST;
            mode        = MODE_INACTIVE;
            session     = '0;
            gen         = '0;
            req_gen     = '0;
            wait_cnt    = '0;
            cmd_age     = '0;
            ext_seen    = 1'b0;
            safe_done   = 1'b0;
            fault_flag  = 1'b0;
            predicted_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_WAIT: max_wait    = i_cfg_data;
                    REG_CMD_TO:   cmd_timeout = i_cfg_data;
                    default:      ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR %0t: result with nothing predicted: %s",
                                 $time, describe(i_out_item));
                end else begin
                    want = predicted_replies.pop_front();
                    if (i_out_item !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("ERROR %0t: result differs from prediction", $time);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(i_out_item));
                        end
                    end
                end
            end

            // Queue the prediction behind the older ones
            if (i_in_valid && !i_in_stall)
                predicted_replies = {predicted_replies, step_protocol(i_in_item)};
        end
        o_owed = predicted_replies.size();
    end

endmodule

// ----- tb/motor_command_safe_stop_handshake_top_tb.sv -----
// ----------------------------------------------------------------------------
// Safe-stop handshake testbench
// Drives directed and random protocol items through the handshake block
// under several register settings, with random sender gaps and receiver
// stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_command_safe_stop_handshake_top_tb;
    import mcssh_pkg::*;

    localparam logic [1:0]       OP_UNDEFINED = 2'd3;
    localparam logic [1:0]       STAT_OTHER   = 2'd3;
    localparam logic [IDX_W-1:0] REG_SPARE_A  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_B  = IDX_W'(3);
    localparam int               HOLD_CYCLES  = 64;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_item   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [WAIT_W-1:0] cfg_data  = '0;
    logic              in_stall;
    logic              out_valid;
    t_out_item         out_item;
    logic              cfg_ready;

    int                fail_count;
    int                owed;
    t_mode             pred_mode;
    logic [GEN_W-1:0]  pred_gen;
    logic [GEN_W-1:0]  pred_safe_gen;
    logic [GEN_W-1:0]  pred_session;

    // Idling controls
    int                burst_left   = 0;
    bit                tx_free      = 1'b0;
    bit                rx_free      = 1'b0;
    int                hold_trigger = 0;
    int                hold_done    = 0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    motor_command_safe_stop_handshake_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    motor_command_safe_stop_handshake_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_owed       (owed),
        .o_mode       (pred_mode),
        .o_gen_count  (pred_gen),
        .o_safe_gen   (pred_safe_gen),
        .o_session    (pred_session)
    );

    function automatic t_in_item mk(input logic [1:0] op, input logic vld,
                                    input logic [GEN_W-1:0] sess, ack, sgen, sack,
                                    input logic [1:0] st, input logic stp, fr);
        t_in_item it;
        it.operation                = op;
        it.observed_valid           = vld;
        it.observed_session         = sess;
        it.observed_ack_generation  = ack;
        it.observed_safe_generation = sgen;
        it.observed_safe_ack        = sack;
        it.observed_status          = st;
        it.stop_request             = stp;
        it.new_command              = fr;
        return it;
    endfunction

    // Offer one item in bursts with random gaps; starts and ends at a falling edge
    task automatic offer(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_free ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain: wait until nothing predicted is left, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (owed != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WAIT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers change only with the block idle; spare indexes must be ignored
    task automatic apply_config(input logic [WAIT_W-1:0] max_wait,
                                input logic [WAIT_W-1:0] cmd_timeout);
        settle();
        write_reg(REG_MAX_WAIT, max_wait);
        write_reg(REG_CMD_TO, cmd_timeout);
        write_reg(REG_SPARE_A, WAIT_W'($urandom));
        write_reg(REG_SPARE_B, WAIT_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Random items shaped after the predicted protocol state, plus noise
    task automatic run_phase(input int count, input int fresh_pct, input int ack_pct);
        t_in_item it;
        int       r;
        int       q;
        int       s;
        for (int k = 0; k < count; k++) begin
            r  = $urandom_range(0, 99);
            q  = $urandom_range(0, 99);
            s  = $urandom_range(0, 99);
            it = mk(OP_TICK, 1'b1, pred_session, pred_gen, $urandom_range(0, 15), $urandom,
                    STAT_ACTIVE, 1'b0, $urandom_range(0, 99) < fresh_pct);
            case (pred_mode)
                MODE_INACTIVE: begin
                    if (r < 80) begin
                        it.operation        = OP_ACTIVATE;
                        it.observed_session = r[0] ? $urandom : $urandom_range(1, 6);
                        it.observed_valid   = (r != 79);
                    end
                end
                MODE_SEEDING, MODE_ACTIVE: begin
                    if (pred_mode == MODE_SEEDING && pred_gen == '0)
                        it.observed_status = STAT_SAFE;
                    if (q >= ack_pct)
                        it.observed_ack_generation = q[0] ? pred_gen - 1'b1 : $urandom;
                    it.stop_request = (r >= 96);
                    if (r == 99)
                        it.observed_safe_generation = GEN_TOP;
                    else if (r == 98)
                        it.observed_safe_generation = $urandom;
                end
                MODE_STOPPING: begin
                    it.observed_status          = q[0] ? STAT_SAFE : STAT_TRANS;
                    it.observed_safe_generation = pred_safe_gen;
                    it.observed_safe_ack = (r < 40) ? pred_safe_gen : pred_safe_gen - 1'b1;
                    it.stop_request      = q[1];
                end
                MODE_SAFE: begin
                    it.operation = (r < 50) ? OP_DEACTIVATE : (r < 80) ? OP_ACTIVATE : OP_TICK;
                    if (q[2])
                        it.observed_session = $urandom_range(1, 6);
                end
                default: begin
                    it.operation = (r < 60) ? OP_ACTIVATE : (r < 80) ? OP_DEACTIVATE : OP_TICK;
                    if (q[2])
                        it.observed_session = $urandom_range(1, 6);
                end
            endcase

            // Noise and broken items
            if (s < 5) begin
                it.operation                = 2'($urandom_range(0, 3));
                it.observed_valid           = 1'($urandom_range(0, 1));
                it.observed_session         = $urandom;
                it.observed_ack_generation  = $urandom;
                it.observed_safe_generation = $urandom;
                it.observed_safe_ack        = $urandom;
                it.observed_status          = 2'($urandom_range(0, 3));
                it.stop_request             = 1'($urandom_range(0, 1));
                it.new_command              = 1'($urandom_range(0, 1));
            end else if (s < 9) begin
                case (s)
                    5:       it.observed_valid = 1'b0;
                    6:       it.observed_session ^= GEN_W'(1) << $urandom_range(0, GEN_W - 1);
                    7:       it.observed_status = STAT_OTHER;
                    default: it.operation = OP_UNDEFINED;
                endcase
            end
            offer(it);
        end
    endtask

    // Receiver: stall runs of its own, long hold-off on request
    initial begin
        int run;
        bit stalled;
        run     = 0;
        stalled = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_done != hold_trigger) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done++;
            end else begin
                if (run == 0) begin
                    stalled = !stalled && !rx_free && ($urandom_range(0, 2) != 0);
                    run     = stalled ? $urandom_range(1, 5) : $urandom_range(1, 16);
                end
                run--;
                out_stall <= stalled;
            end
        end
    end

    // Main sequence
    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, every operation and the corner cases
        offer(mk(OP_TICK, 1'b1, '0, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_DEACTIVATE, 1'b1, '0, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_UNDEFINED, 1'b1, 32'd7, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_ACTIVATE, 1'b0, 32'd7, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_ACTIVATE, 1'b1, '0, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        // Activate with a command that must be dropped
        offer(mk(OP_ACTIVATE, 1'b1, '1, '1, '1, '1, STAT_OTHER, 1'b1, 1'b1));
        offer(mk(OP_TICK, 1'b1, '1, '1, '1, '1, STAT_SAFE, 1'b0, 1'b1));
        offer(mk(OP_TICK, 1'b1, '1, '0, '0, '0, STAT_ACTIVE, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, '1, 32'd1, '0, '0, STAT_ACTIVE, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, '1, 32'd1, '0, '0, STAT_ACTIVE, 1'b0, 1'b1));
        offer(mk(OP_TICK, 1'b1, '1, 32'd2, '0, '0, STAT_ACTIVE, 1'b0, 1'b0));
        // Stop request at the last usable safe generation
        offer(mk(OP_TICK, 1'b1, '1, 32'd3, 32'hFFFF_FFFE, '0, STAT_ACTIVE, 1'b1, 1'b0));
        offer(mk(OP_TICK, 1'b1, '1, 32'd3, '1, '0, STAT_TRANS, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, '1, 32'd3, '1, '1, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, '1, 32'd3, '1, '1, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_DEACTIVATE, 1'b1, '1, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_ACTIVATE, 1'b1, 32'd5, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, 32'd5, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, 32'd5, 32'd1, '0, '0, STAT_ACTIVE, 1'b0, 1'b0));
        // Safe generation at the top of the range cannot be requested
        offer(mk(OP_TICK, 1'b1, 32'd5, 32'd1, '1, '0, STAT_ACTIVE, 1'b1, 1'b0));
        offer(mk(OP_TICK, 1'b1, 32'd5, 32'd1, '0, '0, STAT_ACTIVE, 1'b0, 1'b0));
        offer(mk(OP_DEACTIVATE, 1'b1, 32'd5, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_ACTIVATE, 1'b1, 32'h8000_0001, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));
        offer(mk(OP_TICK, 1'b1, 32'h0000_0001, '0, '0, '0, STAT_SAFE, 1'b0, 1'b0));

        // Random phases over several register settings
        apply_config(WAIT_W'(0), WAIT_W'(1));
        run_phase(280, 70, 85);

        apply_config(WAIT_W'(2), WAIT_W'(3));
        hold_trigger++;
        run_phase(280, 50, 80);

        apply_config('1, '1);
        tx_free = 1'b1;
        rx_free = 1'b1;
        run_phase(280, 90, 95);
        tx_free = 1'b0;
        rx_free = 1'b0;

        apply_config(WAIT_W'(1), WAIT_W'(0));
        run_phase(280, 30, 85);

        apply_config(WAIT_W'(3), WAIT_W'(5));
        run_phase(280, 60, 70);

        apply_config(MAX_WAIT_RST, CMD_TO_RST);
        run_phase(280, 95, 98);

        settle();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
